// File: design/crfq_pkg.sv
package crfq_pkg;

	localparam int QueueDepth = 16;
	localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW       = $clog2(QueueDepth + 1);

	localparam int IdentW     = 30;
	localparam int MaxDataLen = 8;
	localparam int StdIdLen   = 11;
	localparam int ExtIdLen   = 29;
	localparam int WordW      = 32;

	typedef enum logic [1:0] {
		ST_STORED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_POPPED  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_READ = 2'b10
	} fsm_t;

endpackage

// File: design/can_rx_frame_queue.sv
// Receive queue for CAN frames held as a ring in three synchronous entry memories (identifier,
// payload, length), 16 entries. Each item is either an arriving frame (operation 0) or a pop
// (operation 1) and gives exactly one result. When an item is taken, the entry memories are
// read into registers along with the item state; in the read state that follows, the result
// is registered once the output register is free, and no new item is taken until then.
// in_stall is high only in the read state, so a new item is taken while a result still waits
// on out_stall. Ring pointer and count are updated when the item is taken. Entries that were
// never written may be read, but never reach a result; no clearing pass runs after reset.
module can_rx_frame_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] ident_word,
	input  logic [3:0]  length_code,
	input  logic [31:0] data_low_word,
	input  logic [31:0] data_high_word,
	input  logic [7:0]  pop_max_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [28:0] frame_id,
	output logic [4:0]  id_length,
	output logic [63:0] frame_data,
	output logic [3:0]  copied_len,
	output logic [4:0]  entries_held,
	output logic [3:0]  head_length
);

	localparam int PtrW  = crfq_pkg::PtrW;
	localparam int CntW  = crfq_pkg::CntW;
	localparam int Depth = crfq_pkg::QueueDepth;

	// entry memories
	logic [crfq_pkg::IdentW-1:0] ident_mem [Depth];
	logic [63:0]                 payload_mem [Depth];
	logic [3:0]                  length_mem [Depth];

	crfq_pkg::fsm_t state_q;
	logic [PtrW-1:0] head_q;
	logic [CntW-1:0] count_q;

	logic accept, out_free, push_wr;
	logic full, empty;
	logic [PtrW-1:0] head_next, tail;
	logic [CntW:0]   tail_sum;
	logic [3:0]      len_clamp;
	logic [crfq_pkg::IdentW-1:0] ident_dec;

	// item state carried into the read state
	crfq_pkg::status_t status_s1;
	logic [7:0]      maxl_s1;
	logic [3:0]      len_in_s1;
	logic            was_empty_s1, now_empty_s1;
	logic [CntW-1:0] count_s1;

	// registered read data
	logic [crfq_pkg::IdentW-1:0] rd_ident_q;
	logic [63:0] rd_payload_q;
	logic [3:0]  rd_len_q, rd_len_next_q;

	logic [3:0]  n_copy;
	logic [63:0] data_masked;
	logic [3:0]  head_len_res;

	assign in_stall = (state_q == crfq_pkg::FSM_READ);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	assign full  = (count_q >= CntW'(Depth));
	assign empty = (count_q == '0);

	assign head_next = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum  = {{(CntW + 1 - PtrW){1'b0}}, head_q} + {1'b0, count_q};
	assign tail = (tail_sum >= (CntW + 1)'(Depth)) ? PtrW'(tail_sum - (CntW + 1)'(Depth))
	                                               : PtrW'(tail_sum);

	assign len_clamp = (length_code > 4'(crfq_pkg::MaxDataLen)) ? 4'(crfq_pkg::MaxDataLen)
	                                                          : length_code;
	// bit 29 marks an extended identifier
	assign ident_dec = ident_word[2] ? {1'b1, ident_word[31:3]}
	                                 : {19'b0, ident_word[31:21]};

	assign push_wr = accept && (operation == crfq_pkg::OP_ARRIVE) && !full;

	always_ff @(posedge clk) begin
		if (push_wr) begin
			ident_mem[tail]   <= ident_dec;
			payload_mem[tail] <= {data_high_word, data_low_word};
			length_mem[tail]  <= len_clamp;
		end
		if (accept) begin
			rd_ident_q    <= ident_mem[head_q];
			rd_payload_q  <= payload_mem[head_q];
			rd_len_q      <= length_mem[head_q];
			rd_len_next_q <= length_mem[head_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= crfq_pkg::FSM_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				crfq_pkg::FSM_IDLE: begin
					if (out_valid && !out_stall)
						out_valid <= 1'b0;
					if (accept) begin
						state_q <= crfq_pkg::FSM_READ;
						if (operation == crfq_pkg::OP_POP) begin
							if (!empty) begin
								head_q  <= head_next;
								count_q <= count_q - 1'b1;
							end
						end else if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				crfq_pkg::FSM_READ: begin
					// a result still stalled keeps out_valid high
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= crfq_pkg::FSM_IDLE;
					end
				end
				default: state_q <= crfq_pkg::FSM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			maxl_s1      <= pop_max_len;
			len_in_s1    <= len_clamp;
			was_empty_s1 <= empty;
			if (operation == crfq_pkg::OP_POP) begin
				status_s1    <= empty ? crfq_pkg::ST_EMPTY : crfq_pkg::ST_POPPED;
				count_s1     <= empty ? count_q : count_q - 1'b1;
				now_empty_s1 <= (count_q <= CntW'(1));
			end else begin
				status_s1    <= full ? crfq_pkg::ST_DROPPED : crfq_pkg::ST_STORED;
				count_s1     <= full ? count_q : count_q + 1'b1;
				now_empty_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		n_copy = ({4'b0, rd_len_q} < maxl_s1) ? rd_len_q : maxl_s1[3:0];
		for (int i = 0; i < crfq_pkg::MaxDataLen; i++)
			data_masked[8*i +: 8] = (4'(i) < n_copy) ? rd_payload_q[8*i +: 8] : 8'h00;
		case (status_s1)
			crfq_pkg::ST_POPPED: head_len_res = now_empty_s1 ? 4'd0 : rd_len_next_q;
			crfq_pkg::ST_EMPTY:  head_len_res = 4'd0;
			default:             head_len_res = was_empty_s1 ? len_in_s1 : rd_len_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == crfq_pkg::FSM_READ && out_free) begin
			status       <= status_s1;
			entries_held <= 5'(count_s1);
			head_length  <= head_len_res;
			if (status_s1 == crfq_pkg::ST_POPPED) begin
				frame_id   <= rd_ident_q[28:0];
				id_length  <= rd_ident_q[29] ? 5'(crfq_pkg::ExtIdLen) : 5'(crfq_pkg::StdIdLen);
				frame_data <= data_masked;
				copied_len <= n_copy;
			end else begin
				frame_id   <= '0;
				id_length  <= '0;
				frame_data <= '0;
				copied_len <= '0;
			end
		end
	end

endmodule
